### hdl/eci_pkg.sv
// Shared types and constants for the easing curve interpolator.
`timescale 1ns / 1ps
package eci_pkg;

    // Width of the raw time fields and of their differences
    localparam int RAW_WIDTH = 32;
    localparam int MAG_WIDTH = RAW_WIDTH + 1;

    // Operation selector carried in the input word's tuser
    typedef enum logic [1:0] {
        FUNC_SINGLE = 2'd0,
        FUNC_MAPPED = 2'd1,
        FUNC_MIX    = 2'd2,
        FUNC_XFADE  = 2'd3
    } func_t;

    // Curve identifiers
    typedef enum logic [2:0] {
        CURVE_LIN    = 3'd0,
        CURVE_INV    = 3'd1,
        CURVE_START2 = 3'd2,
        CURVE_START3 = 3'd3,
        CURVE_START4 = 3'd4,
        CURVE_STOP2  = 3'd5,
        CURVE_STOP3  = 3'd6,
        CURVE_STOP4  = 3'd7
    } curve_id_t;

endpackage

### hdl/eci_delay.sv
// Enabled shift line that carries side data alongside the arithmetic stages.
`timescale 1ns / 1ps
module eci_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             advance,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Shift one place per advancing cycle
    always_ff @(posedge aclk) begin
        if (advance) begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

### hdl/eci_divider.sv
// Pipelined restoring divider that maps a raw time offset onto 0..one.
`timescale 1ns / 1ps
module eci_divider
    import eci_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic                 valid_in,
    input  logic [MAG_WIDTH-1:0] num_mag,
    input  logic [MAG_WIDTH-1:0] span_mag,
    input  logic                 force_zero,
    output logic                 valid_out,
    output logic [FRAC_BITS:0]   mapped_time
);

    localparam int TW = FRAC_BITS + 1;
    localparam logic [TW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic                 valid_reg [FRAC_BITS+1];
    logic [MAG_WIDTH-1:0] rem_reg   [FRAC_BITS+1];
    logic [MAG_WIDTH-1:0] den_reg   [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] q_reg     [FRAC_BITS+1];
    logic                 one_reg   [FRAC_BITS+1];
    logic                 zero_reg  [FRAC_BITS+1];

    // Entry stage: saturate to one when the offset reaches the span
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (advance) begin
            valid_reg[0] <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg[0]  <= num_mag;
            den_reg[0]  <= span_mag;
            q_reg[0]    <= '0;
            one_reg[0]  <= (num_mag >= span_mag);
            zero_reg[0] <= force_zero;
        end
    end

    // One quotient bit per stage
    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
        logic [MAG_WIDTH:0] shifted;
        logic [MAG_WIDTH:0] diff;
        logic               take;

        always_comb begin
            shifted = {rem_reg[k-1], 1'b0};
            diff    = shifted - {1'b0, den_reg[k-1]};
            take    = (shifted >= {1'b0, den_reg[k-1]});
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (advance) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                rem_reg[k]  <= take ? diff[MAG_WIDTH-1:0] : shifted[MAG_WIDTH-1:0];
                den_reg[k]  <= den_reg[k-1];
                q_reg[k]    <= {q_reg[k-1][FRAC_BITS-2:0], take};
                one_reg[k]  <= one_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    // Pick saturated, zero or divided time
    always_comb begin
        if (zero_reg[FRAC_BITS]) begin
            mapped_time = '0;
        end else if (one_reg[FRAC_BITS]) begin
            mapped_time = ONE;
        end else begin
            mapped_time = {1'b0, q_reg[FRAC_BITS]};
        end
    end

    assign valid_out = valid_reg[FRAC_BITS];

    // Partial remainder stays below the divisor on a real division
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[FRAC_BITS] && !one_reg[FRAC_BITS]
        |-> rem_reg[FRAC_BITS] < den_reg[FRAC_BITS])
        else $error("divider remainder not below divisor");

endmodule

### hdl/eci_curve.sv
// Curve level pipeline: linear, inverted, smooth start and smooth stop.
`timescale 1ns / 1ps
module eci_curve
    import eci_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               valid_in,
    input  curve_id_t          curve_id,
    input  logic [FRAC_BITS:0] t_in,
    output logic               valid_out,
    output logic [FRAC_BITS:0] level
);

    localparam int TW = FRAC_BITS + 1;
    localparam logic [TW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [4:0]    valid_reg;
    curve_id_t     id1_reg, id2_reg, id3_reg, id4_reg;
    logic [TW-1:0] base1_reg, base2_reg, base3_reg;
    logic [TW-1:0] lin1_reg, lin2_reg, lin3_reg, lin4_reg;
    logic [TW-1:0] p2_reg, p2_3_reg, p2_4_reg;
    logic [TW-1:0] p3_reg, p3_4_reg;
    logic [TW-1:0] p4_reg;
    logic [TW-1:0] base1_next, lin1_next, level_next;
    logic [2*TW-1:0] sq, cube, quad;
    logic [TW-1:0] level_reg;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[3:0], valid_in};
        end
    end

    // Choose the power base and the linear level
    always_comb begin
        case (curve_id)
            CURVE_STOP2, CURVE_STOP3, CURVE_STOP4: base1_next = ONE - t_in;
            default:                               base1_next = t_in;
        endcase
        lin1_next = (curve_id == CURVE_INV) ? ONE - t_in : t_in;
    end

    // Truncated fixed-point powers, one product per stage
    always_comb begin
        sq   = base1_reg * base1_reg;
        cube = p2_reg * base2_reg;
        quad = p3_reg * base3_reg;
    end

    // Pick the level for the curve
    always_comb begin
        case (id4_reg)
            CURVE_LIN, CURVE_INV: level_next = lin4_reg;
            CURVE_START2:         level_next = p2_4_reg;
            CURVE_START3:         level_next = p3_4_reg;
            CURVE_START4:         level_next = p4_reg;
            CURVE_STOP2:          level_next = ONE - p2_4_reg;
            CURVE_STOP3:          level_next = ONE - p3_4_reg;
            CURVE_STOP4:          level_next = ONE - p4_reg;
            default:              level_next = lin4_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            id1_reg   <= curve_id;
            base1_reg <= base1_next;
            lin1_reg  <= lin1_next;

            id2_reg   <= id1_reg;
            base2_reg <= base1_reg;
            lin2_reg  <= lin1_reg;
            p2_reg    <= sq[FRAC_BITS +: TW];

            id3_reg   <= id2_reg;
            base3_reg <= base2_reg;
            lin3_reg  <= lin2_reg;
            p2_3_reg  <= p2_reg;
            p3_reg    <= cube[FRAC_BITS +: TW];

            id4_reg   <= id3_reg;
            lin4_reg  <= lin3_reg;
            p2_4_reg  <= p2_3_reg;
            p3_4_reg  <= p3_reg;
            p4_reg    <= quad[FRAC_BITS +: TW];

            level_reg <= level_next;
        end
    end

    assign valid_out = valid_reg[4];
    assign level     = level_reg;

    // Curve levels never leave 0..one
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[4] |-> level_reg <= ONE)
        else $error("curve level above one");

endmodule

### hdl/eci_scale.sv
// Exact scale pipeline: a + trunc((b - a) * c / one).
`timescale 1ns / 1ps
module eci_scale #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          valid_in,
    input  logic signed [VALUE_WIDTH-1:0] a_in,
    input  logic signed [VALUE_WIDTH-1:0] b_in,
    input  logic        [FRAC_BITS:0]     c_in,
    output logic                          valid_out,
    output logic signed [VALUE_WIDTH-1:0] result
);

    localparam int W  = VALUE_WIDTH;
    localparam int TW = FRAC_BITS + 1;
    localparam int PW = W + 1 + TW;

    logic [2:0]           valid_reg;
    logic signed [W-1:0]  a1_reg, a2_reg;
    logic                 neg1_reg, neg2_reg;
    logic [W:0]           mag1_reg;
    logic [TW-1:0]        c1_reg;
    logic [W:0]           part2_reg;
    logic signed [W-1:0]  result_reg;
    logic signed [W:0]    a_ext, b_ext, fwd, back;
    logic [PW-1:0]        prod;
    logic signed [W:0]    sum_next;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[1:0], valid_in};
        end
    end

    // Magnitude and direction of the span
    always_comb begin
        a_ext = (W+1)'(a_in);
        b_ext = (W+1)'(b_in);
        fwd   = b_ext - a_ext;
        back  = a_ext - b_ext;
    end

    // Truncating product of span and weight
    assign prod = mag1_reg * c1_reg;

    // Step from a toward b
    always_comb begin
        if (neg2_reg) begin
            sum_next = (W+1)'(a2_reg) - signed'(part2_reg);
        end else begin
            sum_next = (W+1)'(a2_reg) + signed'(part2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a1_reg     <= a_in;
            neg1_reg   <= (b_in < a_in);
            mag1_reg   <= (b_in < a_in) ? back : fwd;
            c1_reg     <= c_in;

            a2_reg     <= a1_reg;
            neg2_reg   <= neg1_reg;
            part2_reg  <= prod[FRAC_BITS +: W+1];

            result_reg <= sum_next[W-1:0];
        end
    end

    assign valid_out = valid_reg[2];
    assign result    = result_reg;

endmodule

### hdl/easing_curve_interpolator.sv
// Top level of the easing curve interpolator pipeline.
//
//  port group   dir  tdata (low bit up)                         tuser
//  s_t*         in   left_curve right_curve mix_weight          func
//                    norm_time raw_time start_time end_time
//                    low_value high_value, zero padded
//  m_t*         out  value, zero padded                         status
//
//  One word accepted and one word delivered per cycle when not stalled.
//  The restoring divider that maps raw time spends an entry stage and then one
//  stage per fraction bit.
//  aresetn clears every valid bit; payload registers are not reset.
//  A stalled output word freezes the whole pipeline; s_tready drops with it.
`timescale 1ns / 1ps
module easing_curve_interpolator
    import eci_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int TW        = FRAC_BITS + 1,
    localparam int LC_LSB    = 0,
    localparam int RC_LSB    = 3,
    localparam int MIX_LSB   = 6,
    localparam int NORM_LSB  = MIX_LSB + TW,
    localparam int RAW_LSB   = NORM_LSB + TW,
    localparam int START_LSB = RAW_LSB + RAW_WIDTH,
    localparam int END_LSB   = START_LSB + RAW_WIDTH,
    localparam int LOW_LSB   = END_LSB + RAW_WIDTH,
    localparam int HIGH_LSB  = LOW_LSB + VALUE_WIDTH,
    localparam int IN_BITS   = HIGH_LSB + VALUE_WIDTH,
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // left_curve, right_curve, mix_weight, norm_time, raw_time, start_time,
    // end_time, low_value, high_value
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // value
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [0:0]           m_tuser
);

    localparam int W = VALUE_WIDTH;
    localparam logic [TW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam int SB1_W = 2 + 3 + 3 + TW + TW + W + W + 1;
    localparam int SB2_W = 2 + TW + TW + 1;
    localparam int CURVE_LAT = 5;
    localparam int SCALE_LAT = 3;

    logic advance;

    // Pipeline moves whenever the output word is free or being taken
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // ---------------- stage 1: unpack, saturate, raw differences
    logic                  v1_reg;
    func_t                 func1_reg;
    curve_id_t             lc1_reg, rc1_reg;
    logic [TW-1:0]         w1_reg, t1_reg;
    logic signed [W-1:0]   lo1_reg, hi1_reg;
    logic signed [MAG_WIDTH-1:0] num1_reg, span1_reg;
    logic [TW-1:0]         mix_in, norm_in, w_next, t_next;
    logic signed [RAW_WIDTH-1:0] raw_in, start_in, end_in;
    logic signed [MAG_WIDTH-1:0] num_next, span_next;

    always_comb begin
        mix_in    = s_tdata[MIX_LSB +: TW];
        norm_in   = s_tdata[NORM_LSB +: TW];
        raw_in    = signed'(s_tdata[RAW_LSB +: RAW_WIDTH]);
        start_in  = signed'(s_tdata[START_LSB +: RAW_WIDTH]);
        end_in    = signed'(s_tdata[END_LSB +: RAW_WIDTH]);
        w_next    = (mix_in > ONE) ? ONE : mix_in;
        t_next    = (norm_in > ONE) ? ONE : norm_in;
        num_next  = MAG_WIDTH'(raw_in) - MAG_WIDTH'(start_in);
        span_next = MAG_WIDTH'(end_in) - MAG_WIDTH'(start_in);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            func1_reg <= func_t'(s_tuser);
            lc1_reg   <= curve_id_t'(s_tdata[LC_LSB +: 3]);
            rc1_reg   <= curve_id_t'(s_tdata[RC_LSB +: 3]);
            w1_reg    <= w_next;
            t1_reg    <= t_next;
            lo1_reg   <= signed'(s_tdata[LOW_LSB +: W]);
            hi1_reg   <= signed'(s_tdata[HIGH_LSB +: W]);
            num1_reg  <= num_next;
            span1_reg <= span_next;
        end
    end

    // ---------------- stage 2: magnitudes and special cases
    logic                 v2_reg;
    logic [SB1_W-1:0]     sb2_reg;
    logic [MAG_WIDTH-1:0] an2_reg, as2_reg;
    logic                 mzero2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (advance) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            an2_reg    <= num1_reg[MAG_WIDTH-1] ? MAG_WIDTH'(-num1_reg) : num1_reg;
            as2_reg    <= span1_reg[MAG_WIDTH-1] ? MAG_WIDTH'(-span1_reg) : span1_reg;
            mzero2_reg <= (num1_reg == '0) || (num1_reg[MAG_WIDTH-1] != span1_reg[MAG_WIDTH-1]);
            sb2_reg    <= {func1_reg, lc1_reg, rc1_reg, w1_reg, t1_reg, lo1_reg, hi1_reg,
                           (span1_reg == '0)};
        end
    end

    // ---------------- time mapping divider
    logic                 vdiv;
    logic [TW-1:0]        mapped_time;
    logic [SB1_W-1:0]     sb_div;

    eci_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .valid_in    (v2_reg),
        .num_mag     (an2_reg),
        .span_mag    (as2_reg),
        .force_zero  (mzero2_reg),
        .valid_out   (vdiv),
        .mapped_time (mapped_time)
    );

    eci_delay #(
        .WIDTH (SB1_W),
        .DEPTH (FRAC_BITS + 1)
    ) u_div_side (
        .aclk    (aclk),
        .advance (advance),
        .din     (sb2_reg),
        .dout    (sb_div)
    );

    // ---------------- stage T: effective curve time
    func_t               func_d;
    curve_id_t           lc_d, rc_d;
    logic [TW-1:0]       w_d, t_d;
    logic signed [W-1:0] lo_d, hi_d;
    logic                szero_d;

    assign func_d = func_t'(sb_div[SB1_W-1 -: 2]);
    assign lc_d   = curve_id_t'(sb_div[SB1_W-3 -: 3]);
    assign rc_d   = curve_id_t'(sb_div[SB1_W-6 -: 3]);
    assign {w_d, t_d, lo_d, hi_d, szero_d} = sb_div[SB1_W-9:0];

    logic                vt_reg;
    logic [TW-1:0]       teff_reg;
    curve_id_t           lct_reg, rct_reg;
    logic [SB2_W-1:0]    sbt_reg;
    logic [2*W-1:0]      valt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vt_reg <= 1'b0;
        end else if (advance) begin
            vt_reg <= vdiv;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            teff_reg <= (func_d == FUNC_MAPPED) ? mapped_time : t_d;
            lct_reg  <= lc_d;
            rct_reg  <= rc_d;
            sbt_reg  <= {func_d, w_d, t_d, szero_d && (func_d == FUNC_MAPPED)};
            valt_reg <= {lo_d, hi_d};
        end
    end

    // ---------------- curve levels
    logic          vcl, vcr;
    logic [TW-1:0] level_l, level_r;

    eci_curve #(
        .FRAC_BITS (FRAC_BITS)
    ) u_curve_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .valid_in  (vt_reg),
        .curve_id  (lct_reg),
        .t_in      (teff_reg),
        .valid_out (vcl),
        .level     (level_l)
    );

    eci_curve #(
        .FRAC_BITS (FRAC_BITS)
    ) u_curve_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .valid_in  (vt_reg),
        .curve_id  (rct_reg),
        .t_in      (teff_reg),
        .valid_out (vcr),
        .level     (level_r)
    );

    logic [2*W-1:0]      val_c;
    logic signed [W-1:0] lo_c, hi_c;

    eci_delay #(
        .WIDTH (2 * W),
        .DEPTH (CURVE_LAT)
    ) u_curve_side (
        .aclk    (aclk),
        .advance (advance),
        .din     (valt_reg),
        .dout    (val_c)
    );

    assign lo_c = signed'(val_c[2*W-1:W]);
    assign hi_c = signed'(val_c[W-1:0]);

    // ---------------- curve values between low and high
    logic                vsl, vsr;
    logic signed [W-1:0] val_l, val_r;

    eci_scale #(
        .VALUE_WIDTH (W),
        .FRAC_BITS   (FRAC_BITS)
    ) u_scale_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .valid_in  (vcl),
        .a_in      (lo_c),
        .b_in      (hi_c),
        .c_in      (level_l),
        .valid_out (vsl),
        .result    (val_l)
    );

    eci_scale #(
        .VALUE_WIDTH (W),
        .FRAC_BITS   (FRAC_BITS)
    ) u_scale_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .valid_in  (vcr),
        .a_in      (lo_c),
        .b_in      (hi_c),
        .c_in      (level_r),
        .valid_out (vsr),
        .result    (val_r)
    );

    logic [SB2_W-1:0] sb_s;
    func_t            func_s;
    logic [TW-1:0]    w_s, t_s;
    logic             zspan_s;

    eci_delay #(
        .WIDTH (SB2_W),
        .DEPTH (CURVE_LAT + SCALE_LAT)
    ) u_scale_side (
        .aclk    (aclk),
        .advance (advance),
        .din     (sbt_reg),
        .dout    (sb_s)
    );

    assign func_s = func_t'(sb_s[SB2_W-1 -: 2]);
    assign {w_s, t_s, zspan_s} = sb_s[SB2_W-3:0];

    // ---------------- mix or crossfade; single curves mix with themselves
    logic                mix_valid;
    logic signed [W-1:0] mix_b, mix_val;
    logic [TW-1:0]       mix_c;
    logic                zspan_m;

    assign mix_b = (func_s == FUNC_SINGLE || func_s == FUNC_MAPPED) ? val_l : val_r;
    assign mix_c = (func_s == FUNC_MIX) ? w_s : t_s;

    eci_scale #(
        .VALUE_WIDTH (W),
        .FRAC_BITS   (FRAC_BITS)
    ) u_scale_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .valid_in  (vsl),
        .a_in      (val_l),
        .b_in      (mix_b),
        .c_in      (mix_c),
        .valid_out (mix_valid),
        .result    (mix_val)
    );

    eci_delay #(
        .WIDTH (1),
        .DEPTH (SCALE_LAT)
    ) u_status_side (
        .aclk    (aclk),
        .advance (advance),
        .din     (zspan_s),
        .dout    (zspan_m)
    );

    // ---------------- output word register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg;

    assign m_tdata_next = zspan_m ? '0 : M_TDATA_W'(unsigned'(mix_val));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= mix_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= zspan_m;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // Zero span words carry a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero span word with nonzero value");

    // Both curve lanes stay in step
    assert property (@(posedge aclk) disable iff (!aresetn)
        vcl == vcr)
        else $error("curve lanes out of step");

    // Both scale lanes stay in step
    assert property (@(posedge aclk) disable iff (!aresetn)
        vsl == vsr)
        else $error("scale lanes out of step");

endmodule
